@@ sv/clpm_pkg.sv @@
// Shared types and codes for the cursor linked-list pool manager.
// No dependencies; imported by clpm_node_mem and the top level.
`default_nettype none
package clpm_pkg;

  localparam int SZW = 7;   // list size / count width
  localparam int IOW = 32;  // item, key and mask port width

  typedef enum logic [3:0] {
    REQ_CREATE = 4'd0,  REQ_FIRST = 4'd1,   REQ_LAST = 4'd2,    REQ_NEXT = 4'd3,
    REQ_PREV = 4'd4,    REQ_CURR = 4'd5,    REQ_INS_AFT = 4'd6, REQ_INS_BEF = 4'd7,
    REQ_APPEND = 4'd8,  REQ_PREPEND = 4'd9, REQ_REMOVE = 4'd10, REQ_TRIM = 4'd11,
    REQ_CONCAT = 4'd12, REQ_FREE = 4'd13,   REQ_SEARCH = 4'd14, REQ_COUNT = 4'd15
  } req_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FAIL = 2'd1,
    ST_NONE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    Z_START = 2'd0,
    Z_ON    = 2'd1,
    Z_END   = 2'd2
  } zone_t;

  // write enables of the three node memories
  typedef struct packed {
    logic item;
    logic nxt;
    logic prv;
  } nmem_we_t;

endpackage
`default_nettype wire

@@ sv/cursor_linked_list_pool_manager_top.sv @@
// Cursor linked-list pool manager: list heads in registers, nodes in clpm_node_mem.
// Uses clpm_pkg and clpm_node_mem.
//
// Usage:
//   in_*  : one request beat (req_type, list_id, second_list_id, item_value,
//           search_key), valid/ready. in_ready is high while the sequencer idles.
//   out_* : result beats (status, item_out, count_out, new_list_id, last_out),
//           valid/ready. Every request gives one beat, free gives one per item,
//           with last_out marking the final beat of a request.
//   cfg_* : cfg_we writes cfg_wdata into the search mask at once.
// Remove and trim return the node to the free chain in a state after their
//   result beat. Search and free walk the list node by node; each node step
//   is one registered read of the node memory feeding the next address.
// One request is in flight at a time; the output register holds a beat while
//   the next request is accepted, and the sequencer waits at any point where
//   it must emit while out_valid is high and out_ready low.
// Reset (rst_n low, synchronous): all heads free and empty, node free chain
//   in index order, mask all ones. No clearing pass; accepts on the next cycle.
`default_nettype none
module cursor_linked_list_pool_manager_top #(
  parameter int NODES = 64,
  parameter int HEADS = 16,
  parameter int ITEM_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  in_req_type,
  input  wire logic [3:0]  in_list_id,
  input  wire logic [3:0]  in_second_list_id,
  input  wire logic [31:0] in_item_value,
  input  wire logic [31:0] in_search_key,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [31:0]      out_item_out,
  output logic [6:0]       out_count_out,
  output logic [3:0]       out_new_list_id,
  output logic             out_last_out,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);
  import clpm_pkg::*;

  localparam int NIW = $clog2(NODES);
  localparam int NW  = NIW + 1;
  localparam int HIW = (HEADS > 1) ? $clog2(HEADS) : 1;
  localparam int HPW = $clog2(HEADS + 1);
  localparam logic [NW-1:0]  NIL  = NW'(NODES);
  localparam logic [HPW-1:0] HNIL = HPW'(HEADS);

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_NAV, S_ITEM, S_INS2, S_BEF, S_LRD, S_LA, S_LB,
    S_RM, S_TR, S_GIVE, S_CC1, S_CC2, S_FREE, S_SRCH
  } state_t;

  state_t state_r, state_nxt;

  // head file
  logic [NW-1:0]  hfirst_r [HEADS];
  logic [NW-1:0]  hfirst_nxt [HEADS];
  logic [NW-1:0]  hlast_r [HEADS];
  logic [NW-1:0]  hlast_nxt [HEADS];
  logic [NW-1:0]  hcur_r [HEADS];
  logic [NW-1:0]  hcur_nxt [HEADS];
  logic [SZW-1:0] hsize_r [HEADS];
  logic [SZW-1:0] hsize_nxt [HEADS];
  zone_t          hzone_r [HEADS];
  zone_t          hzone_nxt [HEADS];
  logic [HPW-1:0] hfree_r [HEADS];
  logic [HPW-1:0] hfree_nxt [HEADS];
  logic [HEADS-1:0] live_r, live_nxt;
  logic [HPW-1:0] fhh_r, fhh_nxt;
  logic [NW-1:0]  fnh_r, fnh_nxt;
  logic [IOW-1:0] mask_r, mask_nxt;

  // request
  req_t           req_r, req_nxt;
  logic [HIW-1:0] h_r, h_nxt;
  logic           hok_r, hok_nxt;
  logic [HIW-1:0] h2_r, h2_nxt;
  logic           h2ok_r, h2ok_nxt;
  logic [ITEM_BITS-1:0] val_r, val_nxt;
  logic [IOW-1:0] key_r, key_nxt;

  // walk registers
  logic [NW-1:0]  n_r, n_nxt;
  logic [NW-1:0]  at_r, at_nxt;
  logic [NW-1:0]  nx_r, nx_nxt;
  logic [NW-1:0]  c_r, c_nxt;
  logic [NW-1:0]  f2_r, f2_nxt;
  logic [NW-1:0]  l2_r, l2_nxt;
  logic [SZW-1:0] s2_r, s2_nxt;
  logic           ok2_r, ok2_nxt;

  // result register
  logic           out_valid_r, out_valid_nxt;
  status_t        out_status_r, out_status_nxt;
  logic [IOW-1:0] out_item_r, out_item_nxt;
  logic [SZW-1:0] out_count_r, out_count_nxt;
  logic [3:0]     out_id_r, out_id_nxt;
  logic           out_last_r, out_last_nxt;

  // node memory port
  logic                 rd_en;
  logic [NW-1:0]        rd_ptr;
  nmem_we_t             nwe;
  logic [NW-1:0]        wa_item, wa_next, wa_prev;
  logic [ITEM_BITS-1:0] wd_item;
  logic [NW-1:0]        wd_next, wd_prev;
  logic [ITEM_BITS-1:0] rd_item;
  logic [NW-1:0]        rd_next, rd_prev;

  clpm_node_mem #(
    .NODES(NODES), .ITEM_BITS(ITEM_BITS), .NIW(NIW), .NW(NW)
  ) u_nmem (
    .clk(clk), .rst_n(rst_n),
    .rd_en(rd_en), .rd_addr(rd_ptr[NIW-1:0]),
    .we(nwe),
    .wa_item(wa_item[NIW-1:0]), .wd_item(wd_item),
    .wa_next(wa_next[NIW-1:0]), .wd_next(wd_next),
    .wa_prev(wa_prev[NIW-1:0]), .wd_prev(wd_prev),
    .rd_item(rd_item), .rd_next(rd_next), .rd_prev(rd_prev)
  );

  logic [HIW-1:0] hsel;
  logic [NW-1:0]  hf, hl, hc;
  logic [SZW-1:0] hs;
  zone_t          hz;
  logic           can_emit;
  logic [IOW-1:0] item32;

  assign hsel = (state_r == S_CC1) ? h2_r : h_r;
  assign hf = hfirst_r[hsel];
  assign hl = hlast_r[hsel];
  assign hc = hcur_r[hsel];
  assign hs = hsize_r[hsel];
  assign hz = hzone_r[hsel];
  assign can_emit = !out_valid_r || out_ready;
  assign item32 = IOW'(rd_item);
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    logic           emit;
    status_t        e_st;
    logic [IOW-1:0] e_item;
    logic [SZW-1:0] e_cnt;
    logic [3:0]     e_id;
    logic           e_last;
    logic           rel_en;
    logic [HIW-1:0] rel_idx;
    logic [HIW-1:0] nh;
    logic [NW-1:0]  t;

    emit = 1'b0; e_st = ST_OK; e_item = '0; e_cnt = '0; e_id = '0; e_last = 1'b1;
    rel_en = 1'b0; rel_idx = h_r; nh = fhh_r[HIW-1:0]; t = NIL;

    state_nxt = state_r;
    hfirst_nxt = hfirst_r; hlast_nxt = hlast_r; hcur_nxt = hcur_r;
    hsize_nxt = hsize_r; hzone_nxt = hzone_r; hfree_nxt = hfree_r;
    live_nxt = live_r; fhh_nxt = fhh_r; fnh_nxt = fnh_r;
    mask_nxt = cfg_we ? cfg_wdata : mask_r;
    req_nxt = req_r; h_nxt = h_r; hok_nxt = hok_r; h2_nxt = h2_r; h2ok_nxt = h2ok_r;
    val_nxt = val_r; key_nxt = key_r;
    n_nxt = n_r; at_nxt = at_r; nx_nxt = nx_r; c_nxt = c_r;
    f2_nxt = f2_r; l2_nxt = l2_r; s2_nxt = s2_r; ok2_nxt = ok2_r;

    rd_en = 1'b0; rd_ptr = '0;
    nwe = '0; wa_item = '0; wd_item = val_r;
    wa_next = '0; wd_next = NIL; wa_prev = '0; wd_prev = NIL;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt  = req_t'(in_req_type);
          h_nxt    = HIW'(in_list_id);
          hok_nxt  = 32'(in_list_id) < HEADS;
          h2_nxt   = HIW'(in_second_list_id);
          h2ok_nxt = 32'(in_second_list_id) < HEADS;
          val_nxt  = ITEM_BITS'(in_item_value);
          key_nxt  = in_search_key;
          state_nxt = S_DEC;
        end
      end

      S_DEC: begin
        if (req_r == REQ_CREATE) begin
          if (can_emit) begin
            emit = 1'b1;
            if (fhh_r == HNIL) begin
              e_st = ST_FAIL;
            end else begin
              fhh_nxt = hfree_r[nh];
              hfirst_nxt[nh] = NIL; hlast_nxt[nh] = NIL; hcur_nxt[nh] = NIL;
              hsize_nxt[nh] = '0; hzone_nxt[nh] = Z_START; live_nxt[nh] = 1'b1;
              e_id = 4'(nh);
            end
            state_nxt = S_IDLE;
          end
        end else if (!hok_r || !live_r[h_r]) begin
          if (can_emit) begin
            emit = 1'b1; e_st = ST_NONE; state_nxt = S_IDLE;
          end
        end else begin
          case (req_r)
            REQ_FIRST, REQ_LAST: begin
              if (hs == '0) begin
                if (can_emit) begin
                  hcur_nxt[h_r] = NIL; emit = 1'b1; e_st = ST_NONE; state_nxt = S_IDLE;
                end
              end else begin
                t = (req_r == REQ_FIRST) ? hf : hl;
                hcur_nxt[h_r] = t; hzone_nxt[h_r] = Z_ON;
                rd_en = 1'b1; rd_ptr = t; state_nxt = S_ITEM;
              end
            end
            REQ_NEXT: begin
              if (hz == Z_END || hs == '0) begin
                if (can_emit) begin
                  hzone_nxt[h_r] = Z_END; emit = 1'b1; e_st = ST_NONE; state_nxt = S_IDLE;
                end
              end else if (hz == Z_START) begin
                hcur_nxt[h_r] = hf; hzone_nxt[h_r] = Z_ON;
                rd_en = 1'b1; rd_ptr = hf; state_nxt = S_ITEM;
              end else begin
                rd_en = 1'b1; rd_ptr = hc; state_nxt = S_NAV;
              end
            end
            REQ_PREV: begin
              if (hs == '0 || hz == Z_START) begin
                if (can_emit) begin
                  emit = 1'b1; e_st = ST_NONE; state_nxt = S_IDLE;
                end
              end else if (hz == Z_END) begin
                hcur_nxt[h_r] = hl; hzone_nxt[h_r] = Z_ON;
                rd_en = 1'b1; rd_ptr = hl; state_nxt = S_ITEM;
              end else begin
                rd_en = 1'b1; rd_ptr = hc; state_nxt = S_NAV;
              end
            end
            REQ_CURR: begin
              if (hs == '0 || hz != Z_ON) begin
                if (can_emit) begin
                  emit = 1'b1; e_st = ST_NONE; state_nxt = S_IDLE;
                end
              end else begin
                rd_en = 1'b1; rd_ptr = hc; state_nxt = S_ITEM;
              end
            end
            REQ_INS_AFT, REQ_INS_BEF, REQ_APPEND, REQ_PREPEND: begin
              if (fnh_r == NIL) begin
                if (can_emit) begin
                  emit = 1'b1; e_st = ST_FAIL; state_nxt = S_IDLE;
                end
              end else begin
                n_nxt = fnh_r; rd_en = 1'b1; rd_ptr = fnh_r; state_nxt = S_INS2;
              end
            end
            REQ_REMOVE: begin
              if (hs == '0 || hz != Z_ON) begin
                if (can_emit) begin
                  emit = 1'b1; e_st = ST_NONE; state_nxt = S_IDLE;
                end
              end else begin
                c_nxt = hc; rd_en = 1'b1; rd_ptr = hc; state_nxt = S_RM;
              end
            end
            REQ_TRIM: begin
              if (hs == '0) begin
                if (can_emit) begin
                  emit = 1'b1; e_st = ST_NONE; state_nxt = S_IDLE;
                end
              end else begin
                c_nxt = hl; rd_en = 1'b1; rd_ptr = hl; state_nxt = S_TR;
              end
            end
            REQ_CONCAT: begin
              state_nxt = S_CC1;
            end
            REQ_FREE: begin
              if (hf == NIL) begin
                if (can_emit) begin
                  rel_en = 1'b1; emit = 1'b1; e_st = ST_NONE; state_nxt = S_IDLE;
                end
              end else begin
                n_nxt = hf; rd_en = 1'b1; rd_ptr = hf; state_nxt = S_FREE;
              end
            end
            REQ_SEARCH: begin
              if (hz == Z_END || hs == '0) begin
                if (can_emit) begin
                  hzone_nxt[h_r] = Z_END; emit = 1'b1; e_st = ST_NONE; state_nxt = S_IDLE;
                end
              end else begin
                t = (hz == Z_START) ? hf : hc;
                c_nxt = t; rd_en = 1'b1; rd_ptr = t; state_nxt = S_SRCH;
              end
            end
            REQ_COUNT: begin
              if (can_emit) begin
                emit = 1'b1; e_cnt = hs; state_nxt = S_IDLE;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_NAV: begin
        t = (req_r == REQ_NEXT) ? rd_next : rd_prev;
        if (t == NIL) begin
          if (can_emit) begin
            hcur_nxt[h_r] = NIL;
            hzone_nxt[h_r] = (req_r == REQ_NEXT) ? Z_END : Z_START;
            emit = 1'b1; e_st = ST_NONE; state_nxt = S_IDLE;
          end
        end else begin
          hcur_nxt[h_r] = t; hzone_nxt[h_r] = Z_ON;
          rd_en = 1'b1; rd_ptr = t; state_nxt = S_ITEM;
        end
      end

      S_ITEM: begin
        if (can_emit) begin
          emit = 1'b1; e_item = item32; state_nxt = S_IDLE;
        end
      end

      S_INS2: begin
        // pop the free node, store the item, pick the link point
        fnh_nxt = rd_next;
        nwe.item = 1'b1; wa_item = n_r;
        if (hs == '0 || req_r == REQ_PREPEND ||
            (req_r != REQ_APPEND && hz == Z_START)) begin
          at_nxt = NIL; nx_nxt = hf; state_nxt = S_LA;
        end else if (req_r == REQ_APPEND || hz == Z_END) begin
          at_nxt = hl; rd_en = 1'b1; rd_ptr = hl; state_nxt = S_LRD;
        end else if (req_r == REQ_INS_AFT) begin
          at_nxt = hc; rd_en = 1'b1; rd_ptr = hc; state_nxt = S_LRD;
        end else begin
          rd_en = 1'b1; rd_ptr = hc; state_nxt = S_BEF;
        end
      end

      S_BEF: begin
        if (rd_prev == NIL) begin
          at_nxt = NIL; nx_nxt = hf; state_nxt = S_LA;
        end else begin
          at_nxt = rd_prev; rd_en = 1'b1; rd_ptr = rd_prev; state_nxt = S_LRD;
        end
      end

      S_LRD: begin
        nx_nxt = rd_next; state_nxt = S_LA;
      end

      S_LA: begin
        nwe.prv = 1'b1; wa_prev = n_r; wd_prev = at_r;
        nwe.nxt = 1'b1; wa_next = n_r; wd_next = nx_r;
        state_nxt = S_LB;
      end

      S_LB: begin
        if (can_emit) begin
          if (at_r != NIL) begin
            nwe.nxt = 1'b1; wa_next = at_r; wd_next = n_r;
          end else begin
            hfirst_nxt[h_r] = n_r;
          end
          if (nx_r != NIL) begin
            nwe.prv = 1'b1; wa_prev = nx_r; wd_prev = n_r;
          end else begin
            hlast_nxt[h_r] = n_r;
          end
          hcur_nxt[h_r] = n_r; hzone_nxt[h_r] = Z_ON;
          hsize_nxt[h_r] = hs + SZW'(1);
          emit = 1'b1; state_nxt = S_IDLE;
        end
      end

      S_RM: begin
        if (can_emit) begin
          if (rd_prev != NIL) begin
            nwe.nxt = 1'b1; wa_next = rd_prev; wd_next = rd_next;
          end else begin
            hfirst_nxt[h_r] = rd_next;
          end
          if (rd_next != NIL) begin
            nwe.prv = 1'b1; wa_prev = rd_next; wd_prev = rd_prev;
          end else begin
            hlast_nxt[h_r] = rd_prev;
          end
          hcur_nxt[h_r] = rd_next;
          hzone_nxt[h_r] = (rd_next == NIL) ? Z_END : Z_ON;
          emit = 1'b1; e_item = item32; state_nxt = S_GIVE;
        end
      end

      S_TR: begin
        if (can_emit) begin
          if (rd_prev == NIL) begin
            hfirst_nxt[h_r] = NIL; hlast_nxt[h_r] = NIL;
            hcur_nxt[h_r] = NIL; hzone_nxt[h_r] = Z_END;
          end else begin
            nwe.nxt = 1'b1; wa_next = rd_prev; wd_next = NIL;
            hlast_nxt[h_r] = rd_prev; hcur_nxt[h_r] = rd_prev; hzone_nxt[h_r] = Z_ON;
          end
          emit = 1'b1; e_item = item32; state_nxt = S_GIVE;
        end
      end

      S_GIVE: begin
        nwe.nxt = 1'b1; wa_next = c_r; wd_next = fnh_r;
        nwe.prv = 1'b1; wa_prev = c_r; wd_prev = NIL;
        fnh_nxt = c_r;
        hsize_nxt[h_r] = hs - SZW'(1);
        state_nxt = S_IDLE;
      end

      S_CC1: begin
        // hsel points at the second list here
        ok2_nxt = h2ok_r && live_r[h2_r] && (h2_r != h_r);
        f2_nxt = hf; l2_nxt = hl; s2_nxt = hs;
        state_nxt = S_CC2;
      end

      S_CC2: begin
        if (can_emit) begin
          emit = 1'b1; state_nxt = S_IDLE;
          if (!ok2_r) begin
            e_st = ST_NONE;
          end else begin
            if (s2_r != '0) begin
              if (hs == '0) begin
                hfirst_nxt[h_r] = f2_r; hlast_nxt[h_r] = l2_r; hsize_nxt[h_r] = s2_r;
                hcur_nxt[h_r] = NIL; hzone_nxt[h_r] = Z_START;
              end else begin
                nwe.nxt = 1'b1; wa_next = hl; wd_next = f2_r;
                nwe.prv = 1'b1; wa_prev = f2_r; wd_prev = hl;
                hlast_nxt[h_r] = l2_r;
                hsize_nxt[h_r] = hs + s2_r;
              end
            end
            rel_en = 1'b1; rel_idx = h2_r;
          end
        end
      end

      S_FREE: begin
        if (can_emit) begin
          emit = 1'b1; e_item = item32; e_last = (rd_next == NIL);
          nwe.nxt = 1'b1; wa_next = n_r; wd_next = fnh_r;
          nwe.prv = 1'b1; wa_prev = n_r; wd_prev = NIL;
          fnh_nxt = n_r;
          if (rd_next == NIL) begin
            rel_en = 1'b1; state_nxt = S_IDLE;
          end else begin
            n_nxt = rd_next; rd_en = 1'b1; rd_ptr = rd_next;
          end
        end
      end

      S_SRCH: begin
        if ((item32 & mask_r) == key_r) begin
          if (can_emit) begin
            hcur_nxt[h_r] = c_r; hzone_nxt[h_r] = Z_ON;
            emit = 1'b1; e_item = item32; state_nxt = S_IDLE;
          end
        end else if (rd_next == NIL) begin
          if (can_emit) begin
            hcur_nxt[h_r] = NIL; hzone_nxt[h_r] = Z_END;
            emit = 1'b1; e_st = ST_NONE; state_nxt = S_IDLE;
          end
        end else begin
          c_nxt = rd_next; rd_en = 1'b1; rd_ptr = rd_next;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (rel_en) begin
      hfirst_nxt[rel_idx] = NIL; hlast_nxt[rel_idx] = NIL; hcur_nxt[rel_idx] = NIL;
      hsize_nxt[rel_idx] = '0; hzone_nxt[rel_idx] = Z_START;
      live_nxt[rel_idx] = 1'b0;
      hfree_nxt[rel_idx] = fhh_r;
      fhh_nxt = HPW'(rel_idx);
    end

    out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    out_status_nxt = emit ? e_st : out_status_r;
    out_item_nxt = emit ? e_item : out_item_r;
    out_count_nxt = emit ? e_cnt : out_count_r;
    out_id_nxt = emit ? e_id : out_id_r;
    out_last_nxt = emit ? e_last : out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      fnh_r <= '0;
      fhh_r <= '0;
      mask_r <= '1;
      live_r <= '0;
      for (int i = 0; i < HEADS; i++) begin
        hfirst_r[i] <= NIL;
        hlast_r[i] <= NIL;
        hcur_r[i] <= NIL;
        hsize_r[i] <= '0;
        hzone_r[i] <= Z_START;
        hfree_r[i] <= HPW'(i + 1);
      end
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fnh_r <= fnh_nxt;
      fhh_r <= fhh_nxt;
      mask_r <= mask_nxt;
      live_r <= live_nxt;
      hfirst_r <= hfirst_nxt;
      hlast_r <= hlast_nxt;
      hcur_r <= hcur_nxt;
      hsize_r <= hsize_nxt;
      hzone_r <= hzone_nxt;
      hfree_r <= hfree_nxt;
    end
    req_r <= req_nxt; h_r <= h_nxt; hok_r <= hok_nxt;
    h2_r <= h2_nxt; h2ok_r <= h2ok_nxt; val_r <= val_nxt; key_r <= key_nxt;
    n_r <= n_nxt; at_r <= at_nxt; nx_r <= nx_nxt; c_r <= c_nxt;
    f2_r <= f2_nxt; l2_r <= l2_nxt; s2_r <= s2_nxt; ok2_r <= ok2_nxt;
    out_status_r <= out_status_nxt; out_item_r <= out_item_nxt;
    out_count_r <= out_count_nxt; out_id_r <= out_id_nxt; out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_item_out = out_item_r;
  assign out_count_out = out_count_r;
  assign out_new_list_id = out_id_r;
  assign out_last_out = out_last_r;

endmodule
`default_nettype wire

@@ sv/clpm_node_mem.sv @@
// Node store: item, next and prev memories, one shared registered read port.
// Uses clpm_pkg. next/prev rows carry valid bits so reset costs no sweep.
`default_nettype none
module clpm_node_mem #(
  parameter int NODES = 64,
  parameter int ITEM_BITS = 32,
  parameter int NIW = 6,
  parameter int NW = 7
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    rd_en,
  input  wire logic [NIW-1:0]          rd_addr,
  input  wire clpm_pkg::nmem_we_t      we,
  input  wire logic [NIW-1:0]          wa_item,
  input  wire logic [ITEM_BITS-1:0]    wd_item,
  input  wire logic [NIW-1:0]          wa_next,
  input  wire logic [NW-1:0]           wd_next,
  input  wire logic [NIW-1:0]          wa_prev,
  input  wire logic [NW-1:0]           wd_prev,
  output logic [ITEM_BITS-1:0]         rd_item,
  output logic [NW-1:0]                rd_next,
  output logic [NW-1:0]                rd_prev
);
  import clpm_pkg::*;

  localparam logic [NW-1:0] NIL = NW'(NODES);

  logic [ITEM_BITS-1:0] item_mem [NODES];
  logic [NW-1:0]        next_mem [NODES];
  logic [NW-1:0]        prev_mem [NODES];
  logic [NODES-1:0]     nv_r;
  logic [NODES-1:0]     pv_r;

  logic [ITEM_BITS-1:0] item_q_r;
  logic [NW-1:0]        next_q_r;
  logic [NW-1:0]        prev_q_r;
  logic                 nvq_r;
  logic                 pvq_r;
  logic [NIW-1:0]       ra_q_r;

  always_ff @(posedge clk) begin
    if (we.item) item_mem[wa_item] <= wd_item;
    if (we.nxt)  next_mem[wa_next] <= wd_next;
    if (we.prv)  prev_mem[wa_prev] <= wd_prev;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= '0;
      pv_r <= '0;
    end else begin
      if (we.nxt) nv_r[wa_next] <= 1'b1;
      if (we.prv) pv_r[wa_prev] <= 1'b1;
    end
  end

  // registered read, write-first on a same-cycle hit
  always_ff @(posedge clk) begin
    if (rd_en) begin
      ra_q_r   <= rd_addr;
      item_q_r <= (we.item && wa_item == rd_addr) ? wd_item : item_mem[rd_addr];
      next_q_r <= (we.nxt && wa_next == rd_addr) ? wd_next : next_mem[rd_addr];
      prev_q_r <= (we.prv && wa_prev == rd_addr) ? wd_prev : prev_mem[rd_addr];
      nvq_r    <= nv_r[rd_addr] | (we.nxt && wa_next == rd_addr);
      pvq_r    <= pv_r[rd_addr] | (we.prv && wa_prev == rd_addr);
    end
  end

  // unwritten rows read as the reset free chain
  assign rd_item = item_q_r;
  assign rd_next = nvq_r ? next_q_r : (NW'(ra_q_r) + NW'(1));
  assign rd_prev = pvq_r ? prev_q_r : NIL;

endmodule
`default_nettype wire
